### rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants, control types and crc helper for the sync frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int ACK_BYTES_DEF = 16;

    localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
    localparam logic [7:0]  SYNC_SECOND = 8'hA5;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    // controller to datapath
    typedef struct packed {
        logic in_fire;
        logic rd_en;
        logic rd_next;
        logic load_pay;
        logic load_err;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic final_byte;
        logic crc_match;
        logic rd_last;
        logic out_free;
    } t_dp_sts;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/sfr_in_if.sv
// ----------------------------------------------------------------------------
// sfr_in_if
// received byte channel: valid, ready and one serial byte
// ----------------------------------------------------------------------------
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/sfr_out_if.sv
// ----------------------------------------------------------------------------
// sfr_out_if
// result channel: valid, ready, payload byte, last mark and crc error flag
// ----------------------------------------------------------------------------
interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last;
    logic       crc_error;

    modport source (output valid, output payload_byte, output last, output crc_error,
                    input ready);
    modport sink   (input valid, input payload_byte, input last, input crc_error,
                    output ready);
endinterface

### rtl/core/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// controller: byte intake, payload drain sequencing and error result
// ----------------------------------------------------------------------------
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_RECV = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_RECV: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_fire = 1'b1;
                    if (i_sts.final_byte) begin
                        n_state = i_sts.crc_match ? ST_RD : ST_ERR;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_pay = 1'b1;
                    o_cmd.rd_next  = 1'b1;
                    n_state        = i_sts.rd_last ? ST_RECV : ST_RD;
                end
            end
            ST_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_err = 1'b1;
                    n_state        = ST_RECV;
                end
            end
            default: begin
                n_state = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RECV;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/sfr_dp.sv
// ----------------------------------------------------------------------------
// sfr_dp
// datapath: byte counter, crc, payload memory and output register
// ----------------------------------------------------------------------------
module sfr_dp
    import sfr_pkg::*;
#(
    parameter int ACK_BYTES = ACK_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_ready,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    output logic       o_out_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_last,
    output logic       o_crc_error
);

    localparam int         PAYLOAD_LEN = ACK_BYTES - 2;
    localparam int         AW          = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam logic [5:0] CRC_HI_POS  = 6'(ACK_BYTES);
    localparam logic [5:0] FINAL_POS   = 6'(ACK_BYTES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PAYLOAD_LEN - 1);

    logic [5:0]  r_count;
    logic [5:0]  n_count;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_crc_high;
    logic [7:0]  n_crc_high;
    logic [AW-1:0] r_rd_addr;
    logic [7:0]  r_rd_data;

    logic [7:0]  r_mem [PAYLOAD_LEN];
    logic        mem_we;
    logic [5:0]  wr_pos;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_err;

    assign wr_pos = r_count - 6'd2;

    always_comb begin
        n_count    = r_count;
        n_crc      = r_crc;
        n_crc_high = r_crc_high;
        mem_we     = 1'b0;
        if (i_cmd.in_fire) begin
            if (r_count == 6'd0 && i_rx_byte != SYNC_FIRST) begin
                // noise while hunting
            end else if (r_count == 6'd1 && i_rx_byte != SYNC_SECOND) begin
                n_count    = 6'd0;
                n_crc      = CRC_INIT;
                n_crc_high = 8'h00;
            end else if (r_count < CRC_HI_POS) begin
                mem_we  = (r_count >= 6'd2);
                n_crc   = crc_update(r_crc, i_rx_byte);
                n_count = r_count + 6'd1;
            end else if (r_count == CRC_HI_POS) begin
                n_crc_high = i_rx_byte;
                n_count    = r_count + 6'd1;
            end else begin
                n_count    = 6'd0;
                n_crc      = CRC_INIT;
                n_crc_high = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= 6'd0;
            r_crc      <= CRC_INIT;
            r_crc_high <= 8'h00;
        end else begin
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_crc_high <= n_crc_high;
        end
    end

    // payload memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_pos[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
        end else if (i_cmd.rd_next) begin
            r_rd_addr <= (r_rd_addr == LAST_ADDR) ? '0 : r_rd_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_pay || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pay) begin
            r_out_byte <= r_rd_data;
            r_out_last <= (r_rd_addr == LAST_ADDR);
            r_out_err  <= 1'b0;
        end else if (i_cmd.load_err) begin
            r_out_byte <= 8'h00;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    assign o_sts.final_byte = (r_count == FINAL_POS);
    assign o_sts.crc_match  = ({r_crc_high, i_rx_byte} == r_crc);
    assign o_sts.rd_last    = (r_rd_addr == LAST_ADDR);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_last         = r_out_last;
    assign o_crc_error    = r_out_err;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> r_out_last)
        else $error("error result without last mark");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_byte == 8'h00))
        else $error("error result with nonzero byte");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_pay && i_cmd.load_err))
        else $error("payload and error load together");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_pay || i_cmd.load_err) |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while held");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FINAL_POS)
        else $error("byte counter beyond frame");

endmodule

### rtl/core/sync_frame_receiver_crc16_top.sv
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc16_top
// fixed-length frame receiver with sync hunt and crc-16/modbus check
// ----------------------------------------------------------------------------
// The block takes received serial bytes one request at a time, hunts for the
// sync pair 0x5A 0xA5 and then collects a frame of ACK_BYTES + 2 bytes: the
// two sync bytes, ACK_BYTES - 2 payload bytes and a crc, high byte first.
// crc-16/modbus (init 0xFFFF, reflected poly 0xA001) covers the sync bytes
// and the payload. On a match the payload bytes go out in order with last on
// the final one; on a mismatch a single result with crc_error and last set
// and a zero byte goes out. A wrong second sync byte restarts the hunt and
// is dropped. While receiving, a byte is taken every cycle. After the final
// crc byte the intake pauses while the payload drains: each result byte is
// read from the payload memory, then loaded into the output register once
// it is free; an error result is loaded the same way. The output register
// lets the next frame start arriving while the last result still waits.
// The payload memory needs no clearing, every entry is written in a frame
// before it is read.
// ----------------------------------------------------------------------------
module sync_frame_receiver_crc16_top
    import sfr_pkg::*;
#(
    parameter int ACK_BYTES = ACK_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfr_in_if.sink    i_rx,
    sfr_out_if.source o_res
);

    // command and status between controller and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller owns the intake handshake and drain sequencing
    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (i_rx.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath holds counter, crc, payload memory and the output register
    sfr_dp #(
        .ACK_BYTES (ACK_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx.rx_byte),
        .i_out_ready    (o_res.ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_res.valid),
        .o_payload_byte (o_res.payload_byte),
        .o_last         (o_res.last),
        .o_crc_error    (o_res.crc_error)
    );

endmodule
